>>> src/cscl_pkg.sv
package cscl_pkg;

  localparam logic [1:0] SHAPE_BOX      = 2'd0;
  localparam logic [1:0] SHAPE_PLANE    = 2'd1;
  localparam logic [1:0] SHAPE_CYLINDER = 2'd2;
  localparam logic [1:0] SHAPE_SPHERE   = 2'd3;

  // 1 + 1e-6 in Q.32
  localparam logic signed [63:0] BOX_TOL = 64'sd4294971591;
  // magnitude clamp ahead of squaring
  localparam logic signed [63:0] HYP_LIM = 64'sd4611686018427387904;
  localparam logic signed [63:0] S64_MAX = 64'sh7fffffffffffffff;
  localparam logic signed [63:0] S64_MIN = 64'sh8000000000000000;

  typedef struct packed {
    logic signed [63:0] d_early;
    logic signed [63:0] cap;
  } side1_t;

  typedef struct packed {
    logic signed [63:0] d_pre;
  } side2_t;

  function automatic logic signed [63:0] sadd(input logic signed [63:0] a,
                                              input logic signed [63:0] b);
    logic signed [64:0] s;
    s = {a[63], a} + {b[63], b};
    if (s[64] != s[63]) return s[64] ? S64_MIN : S64_MAX;
    return s[63:0];
  endfunction

  function automatic logic signed [63:0] ssub(input logic signed [63:0] a,
                                              input logic signed [63:0] b);
    logic signed [64:0] s;
    s = {a[63], a} - {b[63], b};
    if (s[64] != s[63]) return s[64] ? S64_MIN : S64_MAX;
    return s[63:0];
  endfunction

  function automatic logic signed [63:0] sabs(input logic signed [63:0] a);
    if (!a[63]) return a;
    if (a == S64_MIN) return S64_MAX;
    return -a;
  endfunction

  function automatic logic signed [63:0] sat64(input logic signed [127:0] v);
    if (v[127:63] == {65{v[127]}}) return v[63:0];
    return v[127] ? S64_MIN : S64_MAX;
  endfunction

endpackage

>>> src/cscl_front.sv
module cscl_front #(
  parameter int F = 16
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   en,
  input  logic                   in_vld,
  input  logic [2:0][31:0]       pt,
  input  logic [14:0][47:0]      coefs,
  input  logic [1:0]             shape,
  input  logic [30:0]            half_height,
  output logic                   out_vld,
  output logic [2:0][63:0]       vec,
  output cscl_pkg::side1_t       side
);

  localparam int CSH = 32 - F;
  localparam int OW  = ((F + 15 > 31) ? F + 15 : 31) + 2;
  localparam int AXW = OW + 18;
  localparam int BPW = 80;
  localparam int RPW = 112;
  localparam int OPW = OW + 48;
  localparam int XPW = AXW + 48;

  logic [9:1] vl;

  logic signed [31:0]      p1 [3];
  logic signed [47:0]      k1 [15];

  logic signed [OW-1:0]    off2 [3], off3 [3], off4 [3], off5 [3], off6 [3];
  logic signed [OW-1:0]    off7 [3], off8 [3], off9 [3];
  logic signed [55:0]      bh2 [3][3];
  logic signed [56:0]      bl2 [3][3];
  logic signed [47:0]      tr2 [3], tr3 [3];
  logic signed [47:0]      rc2 [3], rc3 [3], rc4 [3], rc5 [3], rc6 [3], rc7 [3];
  logic signed [47:0]      ax2 [3], ax3 [3], ax4 [3], ax5 [3];
  logic signed [63:0]      bt3 [3][3];
  logic signed [OW+23:0]   oh3 [3];
  logic signed [OW+24:0]   ol3 [3];
  logic signed [63:0]      q4 [3], q5 [3], q6 [3];
  logic signed [63:0]      bt4 [3][2];
  logic signed [63:0]      bt5 [3];
  logic signed [OW+15:0]   tn4 [3];
  logic signed [AXW-1:0]   axl5;
  logic signed [AXW-1:0]   xhh6 [3];
  logic signed [AXW:0]     xhl6 [3];
  logic signed [48:0]      xlh6 [3];
  logic signed [49:0]      xll6 [3];
  logic signed [63:0]      cap6, cap7, cap8, cap9;
  logic signed [63:0]      pd6, pd7, pd8, pd9;
  logic signed [63:0]      aq7 [3];
  logic signed [63:0]      pr7 [3];
  logic signed [55:0]      rhh8 [3];
  logic signed [56:0]      rhl8 [3];
  logic signed [56:0]      rlh8 [3];
  logic signed [57:0]      rll8 [3];
  logic signed [63:0]      rv8 [3], rv9 [3];
  logic signed [63:0]      t9 [3];

  logic signed [OW-1:0]    off_next [3];
  logic signed [55:0]      bh_next [3][3];
  logic signed [56:0]      bl_next [3][3];
  logic signed [63:0]      bt_next [3][3];
  logic signed [OW+23:0]   oh_next [3];
  logic signed [OW+24:0]   ol_next [3];
  logic signed [OW+15:0]   tn_next [3];
  logic signed [AXW-1:0]   xhh_next [3];
  logic signed [AXW:0]     xhl_next [3];
  logic signed [48:0]      xlh_next [3];
  logic signed [49:0]      xll_next [3];
  logic signed [63:0]      pr_next [3];
  logic signed [55:0]      rhh_next [3];
  logic signed [56:0]      rhl_next [3];
  logic signed [56:0]      rlh_next [3];
  logic signed [57:0]      rll_next [3];
  logic signed [63:0]      t_next [3];
  logic signed [63:0]      cap_next;
  logic signed [63:0]      dbox;
  logic [38:0]             hc;

  assign hc = {half_height, 8'd0} >> (24 - F);

  always_comb begin
    logic signed [BPW-1:0] fb;
    logic signed [OPW-1:0] fo;
    logic signed [XPW-1:0] fx;
    logic signed [RPW-1:0] fr;
    logic signed [63:0]    ax64;
    logic signed [63:0]    mag;
    for (int i = 0; i < 3; i++) begin
      off_next[i] = OW'(p1[i]) - OW'(k1[i] >>> CSH);
      oh_next[i]  = off2[i] * $signed(ax2[i][47:24]);
      ol_next[i]  = off2[i] * $signed({1'b0, ax2[i][23:0]});
      fo          = (OPW'(oh3[i]) <<< 24) + OPW'(ol3[i]);
      tn_next[i]  = (OW+16)'(fo >>> 32);
      // axial * axis as four partial products
      xhh_next[i] = $signed(axl5[AXW-1:24]) * $signed(ax5[i][47:24]);
      xhl_next[i] = $signed(axl5[AXW-1:24]) * $signed({1'b0, ax5[i][23:0]});
      xlh_next[i] = $signed({1'b0, axl5[23:0]}) * $signed(ax5[i][47:24]);
      xll_next[i] = $signed({1'b0, axl5[23:0]}) * $signed({1'b0, ax5[i][23:0]});
      fx          = (XPW'(xhh6[i]) <<< 48) + (XPW'(xhl6[i]) <<< 24)
                  + (XPW'(xlh6[i]) <<< 24) + XPW'(xll6[i]);
      pr_next[i]  = cscl_pkg::sat64(128'(fx >>> 32));
      // row excess * reciprocal norm as four partial products
      rhh_next[i] = $signed(aq7[i][63:32]) * $signed(rc7[i][47:24]);
      rhl_next[i] = $signed(aq7[i][63:32]) * $signed({1'b0, rc7[i][23:0]});
      rlh_next[i] = $signed({1'b0, aq7[i][31:0]}) * $signed(rc7[i][47:24]);
      rll_next[i] = $signed({1'b0, aq7[i][31:0]}) * $signed({1'b0, rc7[i][23:0]});
      fr          = (RPW'(rhh8[i]) <<< 56) + (RPW'(rhl8[i]) <<< 32)
                  + (RPW'(rlh8[i]) <<< 24) + RPW'(rll8[i]);
      t_next[i]   = cscl_pkg::sat64(128'(fr >>> (64 - F)));
      for (int c = 0; c < 3; c++) begin
        bh_next[i][c] = $signed(k1[4*i+c][47:24]) * p1[c];
        bl_next[i][c] = $signed({1'b0, k1[4*i+c][23:0]}) * p1[c];
        fb            = (BPW'(bh2[i][c]) <<< 24) + BPW'(bl2[i][c]);
        bt_next[i][c] = cscl_pkg::sat64(128'(fb >>> F));
      end
    end
    ax64     = 64'(axl5);
    mag      = ax64[63] ? -ax64 : ax64;
    cap_next = mag - $signed({25'd0, hc});
    dbox = t9[0];
    if (t9[1] > dbox) dbox = t9[1];
    if (t9[2] > dbox) dbox = t9[2];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vl      <= '0;
      out_vld <= 1'b0;
    end else if (en) begin
      vl      <= {vl[8:1], in_vld};
      out_vld <= vl[9];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        p1[i]   <= $signed(pt[i]);
        off2[i] <= off_next[i];
        off3[i] <= off2[i];
        off4[i] <= off3[i];
        off5[i] <= off4[i];
        off6[i] <= off5[i];
        off7[i] <= off6[i];
        off8[i] <= off7[i];
        off9[i] <= off8[i];
        tr2[i]  <= k1[4*i+3];
        tr3[i]  <= tr2[i];
        rc2[i]  <= k1[12+i];
        rc3[i]  <= rc2[i];
        rc4[i]  <= rc3[i];
        rc5[i]  <= rc4[i];
        rc6[i]  <= rc5[i];
        rc7[i]  <= rc6[i];
        ax2[i]  <= k1[3+i];
        ax3[i]  <= ax2[i];
        ax4[i]  <= ax3[i];
        ax5[i]  <= ax4[i];
        for (int c = 0; c < 3; c++) begin
          bh2[i][c] <= bh_next[i][c];
          bl2[i][c] <= bl_next[i][c];
          bt3[i][c] <= bt_next[i][c];
        end
        oh3[i]    <= oh_next[i];
        ol3[i]    <= ol_next[i];
        q4[i]     <= cscl_pkg::sadd(64'(tr3[i]), bt3[i][0]);
        bt4[i][0] <= bt3[i][1];
        bt4[i][1] <= bt3[i][2];
        tn4[i]    <= tn_next[i];
        q5[i]     <= cscl_pkg::sadd(q4[i], bt4[i][0]);
        bt5[i]    <= bt4[i][1];
        q6[i]     <= cscl_pkg::sadd(q5[i], bt5[i]);
        xhh6[i]   <= xhh_next[i];
        xhl6[i]   <= xhl_next[i];
        xlh6[i]   <= xlh_next[i];
        xll6[i]   <= xll_next[i];
        aq7[i]    <= cscl_pkg::ssub(cscl_pkg::sabs(q6[i]), cscl_pkg::BOX_TOL);
        pr7[i]    <= pr_next[i];
        rhh8[i]   <= rhh_next[i];
        rhl8[i]   <= rhl_next[i];
        rlh8[i]   <= rlh_next[i];
        rll8[i]   <= rll_next[i];
        rv8[i]    <= cscl_pkg::ssub(64'(off7[i]), pr7[i]);
        rv9[i]    <= rv8[i];
        t9[i]     <= t_next[i];
        case (shape)
          cscl_pkg::SHAPE_SPHERE:   vec[i] <= 64'(off9[i]);
          cscl_pkg::SHAPE_CYLINDER: vec[i] <= rv9[i];
          default:                  vec[i] <= '0;
        endcase
      end
      for (int j = 0; j < 15; j++) k1[j] <= $signed(coefs[j]);
      axl5 <= AXW'(tn4[0]) + AXW'(tn4[1]) + AXW'(tn4[2]);
      cap6 <= cap_next;
      cap7 <= cap6;
      cap8 <= cap7;
      cap9 <= cap8;
      pd6  <= -(64'(axl5));
      pd7  <= pd6;
      pd8  <= pd7;
      pd9  <= pd8;
      side.d_early <= (shape == cscl_pkg::SHAPE_BOX) ? dbox : pd9;
      side.cap     <= cap9;
    end
  end

endmodule

>>> src/cscl_sumsq.sv
module cscl_sumsq #(
  parameter int SW = 64
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             en,
  input  logic             in_vld,
  input  logic [2:0][63:0] vin,
  input  logic [SW-1:0]    side_in,
  output logic             out_vld,
  output logic [127:0]     sum,
  output logic [SW-1:0]    side_out
);

  logic [3:1]    vl;
  logic [62:0]   mag [3];
  logic [61:0]   hh [3];
  logic [62:0]   hl [3];
  logic [63:0]   ll [3];
  logic [125:0]  sq [3];
  logic [SW-1:0] sd1, sd2, sd3;
  logic [62:0]   mag_next [3];

  always_comb begin
    logic signed [63:0] m;
    for (int i = 0; i < 3; i++) begin
      m = cscl_pkg::sabs($signed(vin[i]));
      if (m > cscl_pkg::HYP_LIM) m = cscl_pkg::HYP_LIM;
      mag_next[i] = m[62:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vl      <= '0;
      out_vld <= 1'b0;
    end else if (en) begin
      vl      <= {vl[2:1], in_vld};
      out_vld <= vl[3];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        mag[i] <= mag_next[i];
        hh[i]  <= mag[i][62:32] * mag[i][62:32];
        hl[i]  <= mag[i][62:32] * mag[i][31:0];
        ll[i]  <= mag[i][31:0] * mag[i][31:0];
        sq[i]  <= {hh[i], 64'd0} + 126'({hl[i], 33'd0}) + 126'(ll[i]);
      end
      sum      <= 128'(sq[0]) + 128'(sq[1]) + 128'(sq[2]);
      sd1      <= side_in;
      sd2      <= sd1;
      sd3      <= sd2;
      side_out <= sd3;
    end
  end

endmodule

>>> src/cscl_sqrt.sv
module cscl_sqrt #(
  parameter int W  = 64,
  parameter int SW = 64
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             en,
  input  logic             in_vld,
  input  logic [2*W-1:0]   radicand,
  input  logic [SW-1:0]    side_in,
  output logic             out_vld,
  output logic [W-1:0]     root,
  output logic [SW-1:0]    side_out
);

  // one root bit per stage, restoring
  logic [W:0]     rem [W-1];
  logic [2*W-1:0] rad [W-1];
  logic [W-1:0]   rt  [W];
  logic [SW-1:0]  sd  [W];
  logic [W-1:0]   vl;

  for (genvar k = 0; k < W; k++) begin : g_stage
    logic [W:0]     cur_rem;
    logic [2*W-1:0] cur_rad;
    logic [W-1:0]   cur_rt;
    logic [SW-1:0]  cur_sd;
    logic           cur_vl;
    logic [W+2:0]   rin;
    logic [W+2:0]   trial;
    logic [W+2:0]   rnext;
    logic           ge;

    if (k == 0) begin : g_src0
      assign cur_rem = '0;
      assign cur_rad = radicand;
      assign cur_rt  = '0;
      assign cur_sd  = side_in;
      assign cur_vl  = in_vld;
    end else begin : g_srck
      assign cur_rem = rem[k-1];
      assign cur_rad = rad[k-1];
      assign cur_rt  = rt[k-1];
      assign cur_sd  = sd[k-1];
      assign cur_vl  = vl[k-1];
    end

    assign rin   = {cur_rem, cur_rad[2*W-1 -: 2]};
    assign trial = {1'b0, cur_rt, 2'b01};
    assign ge    = rin >= trial;
    assign rnext = ge ? rin - trial : rin;

    always_ff @(posedge clk) begin
      if (rst) begin
        vl[k] <= 1'b0;
      end else if (en) begin
        vl[k] <= cur_vl;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rt[k] <= {cur_rt[W-2:0], ge};
        sd[k] <= cur_sd;
      end
    end

    if (k < W - 1) begin : g_rem
      always_ff @(posedge clk) begin
        if (en) begin
          rem[k] <= rnext[W:0];
          rad[k] <= {cur_rad[2*W-3:0], 2'b00};
        end
      end
    end
  end

  assign out_vld  = vl[W-1];
  assign root     = rt[W-1];
  assign side_out = sd[W-1];

endmodule

>>> src/crop_shape_point_classifier.sv
// Throughput: one point per cycle while in_ready is high; coefficient loads take
// one beat and give no result. Latency is set mostly by two bit-per-stage square
// root pipelines of 64 stages each.
// The pipeline stalls as a whole only when the output skid register is full.
// Synchronous reset clears valid bits and loads shape=sphere, keep_inside=1,
// radius=1.0, half_height=0.5; the coefficient table is undefined until written.
module crop_shape_point_classifier #(
  parameter int COEF_ENTRIES    = 16,
  parameter int COORD_FRAC_BITS = 16
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic               cmd,
  input  logic [3:0]         coef_index,
  input  logic signed [47:0] coef_value,
  input  logic signed [31:0] point_x,
  input  logic signed [31:0] point_y,
  input  logic signed [31:0] point_z,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [31:0] signed_distance,
  output logic               inside_res,
  output logic               kept,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [1:0]         cfg_index,
  input  logic [30:0]        cfg_data
);

  localparam logic [1:0] CFG_SHAPE       = 2'd0;
  localparam logic [1:0] CFG_KEEP_INSIDE = 2'd1;
  localparam logic [1:0] CFG_RADIUS      = 2'd2;
  localparam logic [1:0] CFG_HALF_HEIGHT = 2'd3;
  localparam int IW = $clog2(COEF_ENTRIES);

  typedef struct packed {
    logic signed [31:0] dval;
    logic               ins;
    logic               kept;
  } res_t;

  logic [1:0]  shape;
  logic        keep_inside;
  logic [30:0] radius;
  logic [30:0] half_height;

  logic [47:0]          coef_table [COEF_ENTRIES];
  logic [14:0][47:0]    coefs;
  logic                 en;
  logic                 in_acc;

  logic                 fr_vld;
  logic [2:0][63:0]     fr_vec;
  cscl_pkg::side1_t     fr_side;
  logic                 s1_vld;
  logic [127:0]         s1_sum;
  logic [$bits(cscl_pkg::side1_t)-1:0] s1_side, h1_side_v;
  logic                 h1_vld;
  logic [63:0]          h1_root;
  cscl_pkg::side1_t     h1_side;

  logic                 p1_vld;
  logic signed [63:0]   p1_rad, p1_cap, p1_de;
  logic [2:0][63:0]     v2;
  cscl_pkg::side2_t     side2;
  logic                 s2_vld;
  logic [127:0]         s2_sum;
  logic [$bits(cscl_pkg::side2_t)-1:0] s2_side, h2_side_v;
  logic                 h2_vld;
  logic [63:0]          h2_root;
  cscl_pkg::side2_t     h2_side;

  logic [38:0]          rc;
  logic signed [63:0]   mx;
  logic signed [63:0]   dfin;
  res_t                 res_next;
  logic                 f_vld;
  res_t                 f_res;
  logic                 o_vld, s_vld;
  res_t                 o_res, s_res;

  assign en        = ~s_vld;
  assign in_ready  = en;
  assign in_acc    = in_valid & in_ready;
  assign cfg_ready = 1'b1;
  assign rc        = {radius, 8'd0} >> (24 - COORD_FRAC_BITS);

  always_ff @(posedge clk) begin
    if (rst) begin
      shape       <= cscl_pkg::SHAPE_SPHERE;
      keep_inside <= 1'b1;
      radius      <= 31'd65536;
      half_height <= 31'd32768;
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_SHAPE:       shape       <= cfg_data[1:0];
        CFG_KEEP_INSIDE: keep_inside <= cfg_data[0];
        CFG_RADIUS:      radius      <= cfg_data;
        CFG_HALF_HEIGHT: half_height <= cfg_data;
        default:         shape       <= shape;
      endcase
    end
  end

  // load beats write the table; out-of-range slots are dropped
  always_ff @(posedge clk) begin
    if (in_acc && !cmd && ({1'b0, coef_index} < 5'(COEF_ENTRIES))) begin
      coef_table[coef_index[IW-1:0]] <= coef_value;
    end
  end

  for (genvar j = 0; j < 15; j++) begin : g_coef
    assign coefs[j] = coef_table[j];
  end

  cscl_front #(.F(COORD_FRAC_BITS)) u_front (
    .clk(clk), .rst(rst), .en(en), .in_vld(in_acc & cmd),
    .pt({point_z, point_y, point_x}), .coefs(coefs), .shape(shape),
    .half_height(half_height), .out_vld(fr_vld), .vec(fr_vec), .side(fr_side)
  );

  cscl_sumsq #(.SW($bits(cscl_pkg::side1_t))) u_sumsq1 (
    .clk(clk), .rst(rst), .en(en), .in_vld(fr_vld), .vin(fr_vec), .side_in(fr_side),
    .out_vld(s1_vld), .sum(s1_sum), .side_out(s1_side)
  );

  cscl_sqrt #(.W(64), .SW($bits(cscl_pkg::side1_t))) u_sqrt1 (
    .clk(clk), .rst(rst), .en(en), .in_vld(s1_vld), .radicand(s1_sum), .side_in(s1_side),
    .out_vld(h1_vld), .root(h1_root), .side_out(h1_side_v)
  );
  assign h1_side = h1_side_v;

  always_ff @(posedge clk) begin
    if (rst) begin
      p1_vld <= 1'b0;
    end else if (en) begin
      p1_vld <= h1_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p1_rad <= $signed(h1_root) - $signed({25'd0, rc});
      p1_cap <= h1_side.cap;
      p1_de  <= h1_side.d_early;
    end
  end

  always_comb begin
    mx    = (p1_rad > p1_cap) ? p1_rad : p1_cap;
    v2[0] = p1_rad[63] ? 64'd0 : p1_rad;
    v2[1] = p1_cap[63] ? 64'd0 : p1_cap;
    v2[2] = 64'd0;
    case (shape)
      cscl_pkg::SHAPE_SPHERE:   side2.d_pre = p1_rad;
      cscl_pkg::SHAPE_CYLINDER: side2.d_pre = mx[63] ? mx : 64'sd0;
      default:                  side2.d_pre = p1_de;
    endcase
  end

  cscl_sumsq #(.SW($bits(cscl_pkg::side2_t))) u_sumsq2 (
    .clk(clk), .rst(rst), .en(en), .in_vld(p1_vld), .vin(v2), .side_in(side2),
    .out_vld(s2_vld), .sum(s2_sum), .side_out(s2_side)
  );

  cscl_sqrt #(.W(64), .SW($bits(cscl_pkg::side2_t))) u_sqrt2 (
    .clk(clk), .rst(rst), .en(en), .in_vld(s2_vld), .radicand(s2_sum), .side_in(s2_side),
    .out_vld(h2_vld), .root(h2_root), .side_out(h2_side_v)
  );
  assign h2_side = h2_side_v;

  always_comb begin
    dfin = (shape == cscl_pkg::SHAPE_CYLINDER) ? $signed(h2_root) + h2_side.d_pre
                                               : h2_side.d_pre;
    if (dfin > 64'sd2147483647) res_next.dval = 32'sh7fffffff;
    else if (dfin < -64'sd2147483648) res_next.dval = 32'sh80000000;
    else res_next.dval = dfin[31:0];
    if (shape == cscl_pkg::SHAPE_PLANE) res_next.ins = res_next.dval[31];
    else res_next.ins = res_next.dval[31] | (res_next.dval == 32'sd0);
    res_next.kept = keep_inside ? res_next.ins : ~res_next.ins;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      f_vld <= 1'b0;
    end else if (en) begin
      f_vld <= h2_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) f_res <= res_next;
  end

  // output register plus skid: a result beat parks in the skid while out is held
  always_ff @(posedge clk) begin
    if (rst) begin
      o_vld <= 1'b0;
      s_vld <= 1'b0;
    end else if (out_ready || !o_vld) begin
      if (s_vld) begin
        o_vld <= 1'b1;
        s_vld <= 1'b0;
      end else begin
        o_vld <= f_vld;
      end
    end else if (f_vld && en) begin
      s_vld <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (out_ready || !o_vld) begin
      o_res <= s_vld ? s_res : f_res;
    end else if (f_vld && en) begin
      s_res <= f_res;
    end
  end

  assign out_valid       = o_vld;
  assign signed_distance = o_res.dval;
  assign inside_res      = o_res.ins;
  assign kept            = o_res.kept;

endmodule
